FILE: rtl/core/lrq_pkg.sv
// Shared constants, codes and control types of the line-assembling ring queue.
package lrq_pkg;

    localparam int LINE_SLOTS_DEF = 8;
    localparam int LINE_MAX_DEF   = 256;

    localparam int MODE_W   = 2;
    localparam int CHAR_W   = 8;
    localparam int POS_W    = 8;
    localparam int LEN_W    = 8;
    localparam int STATUS_W = 3;

    localparam logic [MODE_W-1:0] MODE_PUSH    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_READ    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_RELEASE = 2'd2;
    localparam logic [MODE_W-1:0] MODE_NOP     = 2'd3;

    localparam logic [STATUS_W-1:0] ST_STORED    = 3'd0;
    localparam logic [STATUS_W-1:0] ST_COMMIT    = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd2;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_EMPTYLINE = 3'd4;
    localparam logic [STATUS_W-1:0] ST_NOTPUSH   = 3'd5;

    localparam logic [CHAR_W-1:0] CHAR_LF  = 8'h0A;
    localparam logic [CHAR_W-1:0] CHAR_CR  = 8'h0D;
    localparam logic [CHAR_W-1:0] CHAR_NUL = 8'h00;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;   // latch the input beat
        logic exec;      // apply the item to the queue state and memories
        logic rd_issue;  // launch the memory reads for the result
        logic load;      // fill the output register
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free;  // output register empty or being taken this cycle
    } t_sts;

endpackage

FILE: rtl/core/line_assembling_ring_queue_unit.sv
// Top level of the line-assembling ring queue: controller, datapath, checks.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries one beat per command:
//   i_mode selects push (append i_char_in to the line under construction),
//   read (fetch character i_read_position of the oldest committed line) or
//   release (drop the oldest committed line); mode three does nothing.
//   A CR or LF commits the line unless it is empty, the ring is full or it overflows.
//   Output channel (o_out_valid / i_out_stall) returns one beat per command:
//   the read character, head line length, empty/full flags and push status.
// Timing:
//   Each beat walks a four-step sequence (accept, update, memory read,
//   output load); the input stalls until that sequence ends, so no new
//   beat is taken while one is in flight. The pointers are updated before
//   the registered read of the line store and length table.
//   The next beat is accepted while a finished result still waits.
// Reset (synchronous, active low) empties the queue and the output register;
//   no memory clearing pass runs. While i_out_stall is high the result holds
//   and the block stops in its read step once the next beat is done.
module line_assembling_ring_queue_unit #(
    parameter int LINE_SLOTS = lrq_pkg::LINE_SLOTS_DEF,
    parameter int LINE_MAX   = lrq_pkg::LINE_MAX_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [lrq_pkg::MODE_W-1:0]   i_mode,
    input  logic [lrq_pkg::CHAR_W-1:0]   i_char_in,
    input  logic [lrq_pkg::POS_W-1:0]    i_read_position,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [lrq_pkg::CHAR_W-1:0]   o_read_char,
    output logic [lrq_pkg::LEN_W-1:0]    o_head_length,
    output logic                         o_not_empty,
    output logic                         o_full_res,
    output logic [lrq_pkg::STATUS_W-1:0] o_push_status
);

    lrq_pkg::t_cmd cmd;
    lrq_pkg::t_sts sts;

    // Sequence each accepted beat through its steps.
    lrq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // Hold the ring pointers, the line memories and the result register.
    lrq_dp #(
        .LINE_SLOTS (LINE_SLOTS),
        .LINE_MAX   (LINE_MAX)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_mode          (i_mode),
        .i_char_in       (i_char_in),
        .i_read_position (i_read_position),
        .i_out_stall     (i_out_stall),
        .o_out_valid     (o_out_valid),
        .o_read_char     (o_read_char),
        .o_head_length   (o_head_length),
        .o_not_empty     (o_not_empty),
        .o_full_res      (o_full_res),
        .o_push_status   (o_push_status)
    );

`ifndef ASSERT_OFF
    // A full ring always holds at least one committed line.
    a_full_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_full_res) |-> o_not_empty)
        else $error("full reported with empty queue");

    // An empty queue reports no length and no character.
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_not_empty) |-> (o_head_length == '0 && o_read_char == '0))
        else $error("empty queue returned data");

    // Only read beats return a character, so push results carry zero.
    a_push_no_char: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_push_status != lrq_pkg::ST_NOTPUSH) |-> (o_read_char == '0))
        else $error("push beat returned a character");

    // An accepted beat blocks the input until its sequence is done.
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("second beat accepted back to back");
`endif

endmodule

FILE: rtl/core/lrq_ram.sv
// Generic single-write, single-read RAM with registered read data.
module lrq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/core/lrq_ctrl.sv
// Sequencing state machine: accept, execute, read, deliver.
module lrq_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  lrq_pkg::t_sts i_sts,
    output lrq_pkg::t_cmd o_cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_RADR = 2'd2;
    localparam logic [1:0] S_RDAT = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = S_RADR;
            end
            S_RADR: begin
                o_cmd.rd_issue = 1'b1;
                n_state        = S_RDAT;
            end
            S_RDAT: begin
                // hold the read data until the output register frees up
                if (i_sts.out_free) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule

FILE: rtl/core/lrq_dp.sv
// Queue pointers, line memories and output register.
module lrq_dp #(
    parameter int LINE_SLOTS = lrq_pkg::LINE_SLOTS_DEF,
    parameter int LINE_MAX   = lrq_pkg::LINE_MAX_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  lrq_pkg::t_cmd                   i_cmd,
    output lrq_pkg::t_sts                   o_sts,
    input  logic [lrq_pkg::MODE_W-1:0]      i_mode,
    input  logic [lrq_pkg::CHAR_W-1:0]      i_char_in,
    input  logic [lrq_pkg::POS_W-1:0]       i_read_position,
    input  logic                            i_out_stall,
    output logic                            o_out_valid,
    output logic [lrq_pkg::CHAR_W-1:0]      o_read_char,
    output logic [lrq_pkg::LEN_W-1:0]       o_head_length,
    output logic                            o_not_empty,
    output logic                            o_full_res,
    output logic [lrq_pkg::STATUS_W-1:0]    o_push_status
);

    localparam int SW  = $clog2(LINE_SLOTS);
    localparam int PW  = $clog2(LINE_MAX);
    localparam int CW  = (PW > lrq_pkg::POS_W) ? PW : lrq_pkg::POS_W;
    localparam int SAW = SW + PW;

    logic [lrq_pkg::MODE_W-1:0]   r_mode;
    logic [lrq_pkg::CHAR_W-1:0]   r_char;
    logic [lrq_pkg::POS_W-1:0]    r_pos;
    logic [SW-1:0]                r_head;
    logic [SW-1:0]                r_tail;
    logic [PW-1:0]                r_wpos;
    logic [lrq_pkg::STATUS_W-1:0] r_status;
    logic                         r_out_valid;
    logic [lrq_pkg::CHAR_W-1:0]   r_out_char;
    logic [lrq_pkg::LEN_W-1:0]    r_out_len;
    logic                         r_out_ne;
    logic                         r_out_full;
    logic [lrq_pkg::STATUS_W-1:0] r_out_status;

    logic [SW-1:0]                n_head;
    logic [SW-1:0]                n_tail;
    logic [PW-1:0]                n_wpos;
    logic [lrq_pkg::STATUS_W-1:0] n_status;

    logic [SW-1:0]              tail_next;
    logic [SW-1:0]              head_next;
    logic                       full;
    logic                       not_empty;
    logic                       eol;
    logic                       store_we;
    logic                       len_we;
    logic [CW-1:0]              pos_ext;
    logic [CW-1:0]              len_ext;
    logic [PW-1:0]              len_q;
    logic [lrq_pkg::CHAR_W-1:0] store_q;
    logic [lrq_pkg::CHAR_W-1:0] rd_char;

    assign tail_next = (r_tail == SW'(LINE_SLOTS - 1)) ? '0 : r_tail + 1'b1;
    assign head_next = (r_head == SW'(LINE_SLOTS - 1)) ? '0 : r_head + 1'b1;
    assign full      = (tail_next == r_head);
    assign not_empty = (r_head != r_tail);
    assign eol       = (r_char == lrq_pkg::CHAR_LF) || (r_char == lrq_pkg::CHAR_CR);

    // Apply one item to the pointers; memory writes follow the same decisions.
    always_comb begin
        n_head   = r_head;
        n_tail   = r_tail;
        n_wpos   = r_wpos;
        n_status = lrq_pkg::ST_NOTPUSH;
        store_we = 1'b0;
        len_we   = 1'b0;
        unique case (r_mode)
            lrq_pkg::MODE_PUSH: begin
                priority if (full) begin
                    n_status = lrq_pkg::ST_FULL;
                end else if (r_wpos >= PW'(LINE_MAX - 1)) begin
                    n_wpos   = '0;
                    n_status = lrq_pkg::ST_OVERFLOW;
                end else if (eol && (r_wpos == '0)) begin
                    n_status = lrq_pkg::ST_EMPTYLINE;
                end else if (eol) begin
                    len_we   = i_cmd.exec;
                    n_tail   = tail_next;
                    n_wpos   = '0;
                    n_status = lrq_pkg::ST_COMMIT;
                end else begin
                    store_we = i_cmd.exec;
                    n_wpos   = r_wpos + 1'b1;
                    n_status = lrq_pkg::ST_STORED;
                end
            end
            lrq_pkg::MODE_RELEASE: begin
                if (not_empty) begin
                    n_head = head_next;
                end
            end
            lrq_pkg::MODE_READ, lrq_pkg::MODE_NOP: begin
                n_status = lrq_pkg::ST_NOTPUSH;
            end
            default: n_status = lrq_pkg::ST_NOTPUSH;
        endcase
    end

    lrq_ram #(
        .WIDTH (lrq_pkg::CHAR_W),
        .DEPTH (LINE_SLOTS << PW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (store_we),
        .i_waddr ({r_tail, r_wpos}),
        .i_wdata (r_char),
        .i_re    (i_cmd.rd_issue),
        .i_raddr (SAW'({r_head, pos_ext[PW-1:0]})),
        .o_rdata (store_q)
    );

    lrq_ram #(
        .WIDTH (PW),
        .DEPTH (LINE_SLOTS)
    ) u_len (
        .i_clk   (i_clk),
        .i_we    (len_we),
        .i_waddr (r_tail),
        .i_wdata (r_wpos),
        .i_re    (i_cmd.rd_issue),
        .i_raddr (r_head),
        .o_rdata (len_q)
    );

    assign pos_ext = CW'(r_pos);
    assign len_ext = CW'(len_q);
    assign rd_char = ((r_mode == lrq_pkg::MODE_READ) && not_empty && (pos_ext < len_ext))
                     ? store_q : lrq_pkg::CHAR_NUL;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_tail      <= '0;
            r_wpos      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.exec) begin
                r_head <= n_head;
                r_tail <= n_tail;
                r_wpos <= n_wpos;
            end
            if (i_cmd.load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_mode <= i_mode;
            r_char <= i_char_in;
            r_pos  <= i_read_position;
        end
        if (i_cmd.exec) begin
            r_status <= n_status;
        end
        if (i_cmd.load) begin
            r_out_char   <= rd_char;
            r_out_len    <= not_empty ? len_ext[lrq_pkg::LEN_W-1:0] : '0;
            r_out_ne     <= not_empty;
            r_out_full   <= full;
            r_out_status <= r_status;
        end
    end

    assign o_sts.out_free = !r_out_valid || !i_out_stall;
    assign o_out_valid    = r_out_valid;
    assign o_read_char    = r_out_char;
    assign o_head_length  = r_out_len;
    assign o_not_empty    = r_out_ne;
    assign o_full_res     = r_out_full;
    assign o_push_status  = r_out_status;

endmodule
